>>> design/stffa_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the slot table with first-free allocation.
// Used by the controller, the datapath and the top level; depends on nothing.
package stffa_pkg;

    // Width of one search group of valid bits and of an offset inside it.
    localparam int GRP_SIZE = 16;
    localparam int GRP_BITS = 4;

    typedef enum logic [2:0] {
        MODE_INSERT = 3'd0,
        MODE_WRITE  = 3'd1,
        MODE_REMOVE = 3'd2,
        MODE_READ   = 3'd3,
        MODE_QUERY  = 3'd4,
        MODE_RESIZE = 3'd5
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_RANGE  = 2'd1,
        ST_UNUSED = 2'd2,
        ST_FULL   = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE  = 2'd0,
        S_EXEC  = 2'd1,
        S_SWEEP = 2'd2
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic exec;
        logic sweep;
    } ctl_cmd_t;

    // Status from the datapath back to the controller.
    typedef struct packed {
        logic is_resize;
        logic sweep_last;
    } dp_stat_t;

endpackage

>>> design/slot_table_first_free_alloc.sv
`timescale 1ns / 1ps
// Top level of the slot table with valid bits and first-free allocation.
// Instantiates stffa_ctrl and stffa_dp; uses types from stffa_pkg.
//
// Usage:
//   A request is taken at a rising edge where start is high and busy is low; mode,
//   slot_index, value_in and new_size are sampled at that edge. Its result appears
//   on slot_out, value_out, slot_valid, status, used_count and active_size for
//   exactly one cycle, flagged by done. The receiver has no way to stall, so the
//   result must be captured in that cycle.
//   For insert, write, remove, read, valid query and unknown modes, the request
//   edge captures the request, the per-group first-free search over the valid
//   bits and the registered memory read; the execute state then decides and
//   writes, and done is registered at its end. Busy is high in the execute state
//   and already low in the done cycle, so the next request can be taken while the
//   result is shown.
//   Resize runs the execute state and then a sweep state: the valid bits are
//   swept one group of 16 per cycle to clear slots at or above the new size and
//   to update the used count, and done is registered after the last group.
//   grow_step is written with cfg_we and cfg_wdata while no request is pending.
//   Reset empties the table: no slot in use, active size zero, grow step one. The
//   data memory is not cleared; no request can read a slot that was never written.
module slot_table_first_free_alloc
#(
    parameter int CAPACITY   = 256,
    parameter int DATA_WIDTH = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  mode,
    input  logic [7:0]  slot_index,
    input  logic [31:0] value_in,
    input  logic [8:0]  new_size,
    input  logic        cfg_we,
    input  logic [8:0]  cfg_wdata,
    output logic        done,
    output logic [7:0]  slot_out,
    output logic [31:0] value_out,
    output logic        slot_valid,
    output logic [1:0]  status,
    output logic [8:0]  used_count,
    output logic [8:0]  active_size
);

    // Commands flow from the controller, status flows back from the datapath.
    stffa_pkg::ctl_cmd_t cmd;
    stffa_pkg::dp_stat_t stat;

    stffa_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .busy  (busy),
        .cmd   (cmd)
    );

    stffa_dp
    #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    )
    u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .mode        (mode),
        .slot_index  (slot_index),
        .value_in    (value_in),
        .new_size    (new_size),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .done        (done),
        .slot_out    (slot_out),
        .value_out   (value_out),
        .slot_valid  (slot_valid),
        .status      (status),
        .used_count  (used_count),
        .active_size (active_size)
    );

`ifndef SYNTH
    // When a result is flagged, the slots in use lie inside the active table.
    a_count_le_size: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (used_count <= active_size))
        else $error("used count exceeds active size");

    // A taken request always moves the controller out of idle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("request taken but controller stayed idle");

    // A result is only flagged once the controller has finished the request.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result flagged while controller busy");

    // A slot reported in use cannot carry a range or unused status.
    a_valid_status: assert property (@(posedge clk) disable iff (!rst_n)
        (done && slot_valid) |->
            (status != stffa_pkg::ST_RANGE && status != stffa_pkg::ST_UNUSED))
        else $error("valid slot reported with error status");
`endif

endmodule

>>> design/stffa_ctrl.sv
`timescale 1ns / 1ps
// Sequencing state machine for the slot table.
// Depends on stffa_pkg for the state, command and status types.
module stffa_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  stffa_pkg::dp_stat_t  stat,
    output logic                 busy,
    output stffa_pkg::ctl_cmd_t  cmd
);

    stffa_pkg::state_t state_reg;
    stffa_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= stffa_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        unique case (state_reg)
            stffa_pkg::S_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = stffa_pkg::S_EXEC;
                end
            end
            stffa_pkg::S_EXEC:
            begin
                cmd.exec = 1'b1;
                if (stat.is_resize)
                begin
                    state_next = stffa_pkg::S_SWEEP;
                end
                else
                begin
                    state_next = stffa_pkg::S_IDLE;
                end
            end
            stffa_pkg::S_SWEEP:
            begin
                cmd.sweep = 1'b1;
                if (stat.sweep_last)
                begin
                    state_next = stffa_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = stffa_pkg::S_IDLE;
            end
        endcase
    end

endmodule

>>> design/stffa_dp.sv
`timescale 1ns / 1ps
// Datapath of the slot table: data memory, valid bits, size and count registers,
// first-free search and the result registers. Depends on stffa_pkg.
module stffa_dp
#(
    parameter int CAPACITY   = 256,
    parameter int DATA_WIDTH = 32
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  stffa_pkg::ctl_cmd_t  cmd,
    output stffa_pkg::dp_stat_t  stat,
    input  logic [2:0]           mode,
    input  logic [7:0]           slot_index,
    input  logic [31:0]          value_in,
    input  logic [8:0]           new_size,
    input  logic                 cfg_we,
    input  logic [8:0]           cfg_wdata,
    output logic                 done,
    output logic [7:0]           slot_out,
    output logic [31:0]          value_out,
    output logic                 slot_valid,
    output logic [1:0]           status,
    output logic [8:0]           used_count,
    output logic [8:0]           active_size
);

    localparam int GS     = stffa_pkg::GRP_SIZE;
    localparam int GB     = stffa_pkg::GRP_BITS;
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int IDX_W  = $clog2(CAPACITY);
    localparam int NGRP   = (CAPACITY + GS - 1) / GS;
    localparam int GP_W   = (NGRP > 1) ? $clog2(NGRP) : 1;
    localparam int VPAD   = NGRP * GS;
    localparam int VIDX_W = $clog2(VPAD);
    localparam int SUM_W  = ((CNT_W > 9) ? CNT_W : 9) + 1;

    function automatic logic [GB:0] first_free(input logic [GS-1:0] v);
        logic [GB:0] r;
        r = '0;
        for (int j = GS - 1; j >= 0; j--)
        begin
            if (v[j])
            begin
                r = {1'b1, GB'(j)};
            end
        end
        return r;
    endfunction

    function automatic logic [GB:0] pop_count(input logic [GS-1:0] v);
        logic [GB:0] r;
        r = '0;
        for (int j = 0; j < GS; j++)
        begin
            r = r + (GB + 1)'(v[j]);
        end
        return r;
    endfunction

    // Request registers.
    logic [2:0]            mode_reg;
    logic [7:0]            idx_reg;
    logic [DATA_WIDTH-1:0] val_reg;
    logic [8:0]            req_reg;

    // Table state.
    logic [VPAD-1:0]       valid_reg;
    logic [VPAD-1:0]       valid_next;
    logic [CNT_W-1:0]      size_reg;
    logic [CNT_W-1:0]      size_next;
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    logic [8:0]            grow_reg;
    logic [GP_W-1:0]       ptr_reg;
    logic [GP_W-1:0]       ptr_next;

    // Per-group first-free results, captured when a request is taken.
    logic [NGRP-1:0]       grp_any_reg;
    logic [NGRP-1:0]       grp_any_next;
    logic [GB-1:0]         grp_off_reg  [NGRP];
    logic [GB-1:0]         grp_off_next [NGRP];
    logic [VPAD-1:0]       free_vec;

    // Data memory.
    logic [DATA_WIDTH-1:0] mem [CAPACITY];
    logic [DATA_WIDTH-1:0] rd_data_reg;
    logic                  mem_we;
    logic [IDX_W-1:0]      mem_waddr;

    // Result registers.
    logic                  done_reg;
    logic [7:0]            slot_out_reg;
    logic [31:0]           value_out_reg;
    logic                  slot_valid_reg;
    stffa_pkg::status_t    status_reg;

    logic                  emit;
    logic [7:0]            res_slot;
    logic [31:0]           res_value;
    logic                  res_valid;
    stffa_pkg::status_t    res_status;

    // Decoded request conditions.
    logic                  in_range;
    logic [VIDX_W-1:0]     idx_v;
    logic                  idx_used;
    logic                  found;
    logic [GP_W-1:0]       gsel;
    logic                  full;
    logic [VIDX_W-1:0]     ins_slot;
    logic [8:0]            step;
    logic [SUM_W-1:0]      grown_sum;
    logic [CNT_W-1:0]      size_grown;
    logic                  req_over;
    logic [CNT_W-1:0]      req_sat;
    logic [VIDX_W-1:0]     grp_base;
    logic [GS-1:0]         grp_bits;
    logic [GS-1:0]         grp_keep;

    for (genvar i = 0; i < VPAD; i++)
    begin : g_free
        assign free_vec[i] = !valid_reg[i] && (SUM_W'(i) < SUM_W'(size_reg));
    end

    always_comb
    begin
        logic [GB:0] ff;
        for (int g = 0; g < NGRP; g++)
        begin
            ff              = first_free(free_vec[g * GS +: GS]);
            grp_any_next[g] = ff[GB];
            grp_off_next[g] = ff[GB-1:0];
        end
    end

    assign in_range = SUM_W'(idx_reg) < SUM_W'(size_reg);
    assign idx_v    = VIDX_W'(idx_reg);
    assign idx_used = valid_reg[idx_v];

    always_comb
    begin
        found = 1'b0;
        gsel  = '0;
        for (int g = NGRP - 1; g >= 0; g--)
        begin
            if (grp_any_reg[g])
            begin
                found = 1'b1;
                gsel  = GP_W'(g);
            end
        end
    end

    assign full       = !found && (SUM_W'(size_reg) >= SUM_W'(CAPACITY));
    assign ins_slot   = found ? VIDX_W'({gsel, grp_off_reg[gsel]}) : VIDX_W'(size_reg);
    assign step       = (grow_reg == 9'd0) ? 9'd1 : grow_reg;
    assign grown_sum  = SUM_W'(size_reg) + SUM_W'(step);
    assign size_grown = (grown_sum > SUM_W'(CAPACITY)) ? CNT_W'(CAPACITY) : CNT_W'(grown_sum);
    assign req_over   = SUM_W'(req_reg) > SUM_W'(CAPACITY);
    assign req_sat    = req_over ? CNT_W'(CAPACITY) : CNT_W'(req_reg);

    // Sweep view of the group under the pointer: bits at or above the size are dropped.
    assign grp_base = VIDX_W'({ptr_reg, GB'(0)});
    assign grp_bits = valid_reg[grp_base +: GS];

    for (genvar j = 0; j < GS; j++)
    begin : g_keep
        assign grp_keep[j] = SUM_W'({ptr_reg, GB'(j)}) < SUM_W'(size_reg);
    end

    assign stat.is_resize  = (mode_reg == stffa_pkg::MODE_RESIZE);
    assign stat.sweep_last = (ptr_reg == GP_W'(NGRP - 1));

    always_comb
    begin
        valid_next = valid_reg;
        size_next  = size_reg;
        count_next = count_reg;
        ptr_next   = ptr_reg;
        mem_we     = 1'b0;
        mem_waddr  = IDX_W'(idx_v);
        emit       = 1'b0;
        res_slot   = idx_reg;
        res_value  = '0;
        res_valid  = 1'b0;
        res_status = stffa_pkg::ST_OK;

        if (cmd.exec)
        begin
            emit = 1'b1;
            unique case (mode_reg)
                stffa_pkg::MODE_INSERT:
                begin
                    if (full)
                    begin
                        res_status = stffa_pkg::ST_FULL;
                        res_slot   = '0;
                    end
                    else
                    begin
                        mem_we               = 1'b1;
                        mem_waddr            = IDX_W'(ins_slot);
                        valid_next[ins_slot] = 1'b1;
                        count_next           = count_reg + CNT_W'(1);
                        if (!found)
                        begin
                            size_next = size_grown;
                        end
                        res_slot  = 8'(ins_slot);
                        res_valid = 1'b1;
                    end
                end
                stffa_pkg::MODE_WRITE:
                begin
                    if (!in_range)
                    begin
                        res_status = stffa_pkg::ST_RANGE;
                    end
                    else
                    begin
                        mem_we            = 1'b1;
                        valid_next[idx_v] = 1'b1;
                        if (!idx_used)
                        begin
                            count_next = count_reg + CNT_W'(1);
                        end
                        res_valid = 1'b1;
                    end
                end
                stffa_pkg::MODE_REMOVE:
                begin
                    if (!in_range)
                    begin
                        res_status = stffa_pkg::ST_RANGE;
                    end
                    else if (!idx_used)
                    begin
                        res_status = stffa_pkg::ST_UNUSED;
                    end
                    else
                    begin
                        valid_next[idx_v] = 1'b0;
                        count_next        = count_reg - CNT_W'(1);
                    end
                end
                stffa_pkg::MODE_READ:
                begin
                    if (!in_range)
                    begin
                        res_status = stffa_pkg::ST_RANGE;
                    end
                    else if (!idx_used)
                    begin
                        res_status = stffa_pkg::ST_UNUSED;
                    end
                    else
                    begin
                        res_value = 32'(rd_data_reg);
                        res_valid = 1'b1;
                    end
                end
                stffa_pkg::MODE_QUERY:
                begin
                    if (!in_range)
                    begin
                        res_status = stffa_pkg::ST_RANGE;
                    end
                    res_valid = in_range && idx_used;
                end
                stffa_pkg::MODE_RESIZE:
                begin
                    // The result waits for the sweep to settle the count.
                    emit      = 1'b0;
                    size_next = req_sat;
                    ptr_next  = '0;
                end
                default:
                begin
                    res_valid = in_range && idx_used;
                end
            endcase
        end

        if (cmd.sweep)
        begin
            valid_next[grp_base +: GS] = grp_bits & grp_keep;
            count_next = count_reg - CNT_W'(pop_count(grp_bits & ~grp_keep));
            ptr_next   = ptr_reg + GP_W'(1);
            if (stat.sweep_last)
            begin
                emit       = 1'b1;
                res_status = req_over ? stffa_pkg::ST_FULL : stffa_pkg::ST_OK;
                res_valid  = in_range && idx_used;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            size_reg  <= '0;
            count_reg <= '0;
            grow_reg  <= 9'd1;
            ptr_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            size_reg  <= size_next;
            count_reg <= count_next;
            ptr_reg   <= ptr_next;
            done_reg  <= emit;
            if (cfg_we)
            begin
                grow_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg    <= mode;
            idx_reg     <= slot_index;
            val_reg     <= DATA_WIDTH'(value_in);
            req_reg     <= new_size;
            grp_any_reg <= grp_any_next;
            grp_off_reg <= grp_off_next;
        end
        if (emit)
        begin
            slot_out_reg   <= res_slot;
            value_out_reg  <= res_value;
            slot_valid_reg <= res_valid;
            status_reg     <= res_status;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            rd_data_reg <= mem[IDX_W'(slot_index)];
        end
        if (mem_we)
        begin
            mem[mem_waddr] <= val_reg;
        end
    end

    assign done        = done_reg;
    assign slot_out    = slot_out_reg;
    assign value_out   = value_out_reg;
    assign slot_valid  = slot_valid_reg;
    assign status      = status_reg;
    assign used_count  = 9'(count_reg);
    assign active_size = 9'(size_reg);

endmodule

>>> sim/stffa_table_monitor.sv
`timescale 1ns / 1ps
// Monitor for the slot table: predicts every result from accepted requests and checks it.
// Watches the ports of slot_table_first_free_alloc; uses types from stffa_pkg.
module stffa_table_monitor
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [2:0]  mode,
    input  logic [7:0]  slot_index,
    input  logic [31:0] value_in,
    input  logic [8:0]  new_size,
    input  logic        cfg_we,
    input  logic [8:0]  cfg_wdata,
    input  logic        done,
    input  logic [7:0]  slot_out,
    input  logic [31:0] value_out,
    input  logic        slot_valid,
    input  logic [1:0]  status,
    input  logic [8:0]  used_count,
    input  logic [8:0]  active_size,
    output int          mismatches,
    output int          results_seen,
    output int          outstanding,
    output logic [8:0]  size_hint
);

    localparam int TABLE_SLOTS = 256;

    typedef struct packed {
        logic [7:0]          slot;
        logic [31:0]         value;
        logic                valid;
        stffa_pkg::status_t  status;
        logic [8:0]          used;
        logic [8:0]          size;
    } table_reply_t;

    logic [31:0]  slot_word [TABLE_SLOTS];
    bit           slot_taken [TABLE_SLOTS];
    int           table_size;
    int           taken_count;
    int           grow_by;
    table_reply_t replies_due [$];

    // Applies one request to the table copy and returns the reply it should produce.
    function automatic table_reply_t apply_request(input logic [2:0] op,
                                                   input logic [7:0] idx,
                                                   input logic [31:0] val,
                                                   input logic [8:0] want);
        table_reply_t r;
        int           i;
        int           slot;
        int           pick;
        int           target;
        bit           found;
        slot     = idx;
        pick     = 0;
        found    = 1'b0;
        target   = want;
        r.value  = '0;
        r.status = stffa_pkg::ST_OK;
        case (op)
            stffa_pkg::MODE_INSERT:
            begin
                for (i = 0; i < table_size; i++)
                begin
                    if (!found && !slot_taken[i])
                    begin
                        found = 1'b1;
                        pick  = i;
                    end
                end
                if (!found && table_size >= TABLE_SLOTS)
                begin
                    r.status = stffa_pkg::ST_FULL;
                    slot     = 0;
                end
                else
                begin
                    if (!found)
                    begin
                        // No hole: the first slot of the grown region takes the value.
                        pick       = table_size;
                        table_size = table_size + ((grow_by == 0) ? 1 : grow_by);
                        if (table_size > TABLE_SLOTS)
                            table_size = TABLE_SLOTS;
                    end
                    slot_word[pick]  = val;
                    slot_taken[pick] = 1'b1;
                    taken_count++;
                    slot = pick;
                end
            end
            stffa_pkg::MODE_WRITE:
            begin
                if (idx >= table_size)
                    r.status = stffa_pkg::ST_RANGE;
                else
                begin
                    slot_word[idx] = val;
                    if (!slot_taken[idx])
                    begin
                        slot_taken[idx] = 1'b1;
                        taken_count++;
                    end
                end
            end
            stffa_pkg::MODE_REMOVE:
            begin
                if (idx >= table_size)
                    r.status = stffa_pkg::ST_RANGE;
                else if (!slot_taken[idx])
                    r.status = stffa_pkg::ST_UNUSED;
                else
                begin
                    slot_taken[idx] = 1'b0;
                    taken_count--;
                end
            end
            stffa_pkg::MODE_READ:
            begin
                if (idx >= table_size)
                    r.status = stffa_pkg::ST_RANGE;
                else if (!slot_taken[idx])
                    r.status = stffa_pkg::ST_UNUSED;
                else
                    r.value = slot_word[idx];
            end
            stffa_pkg::MODE_QUERY:
            begin
                if (idx >= table_size)
                    r.status = stffa_pkg::ST_RANGE;
            end
            stffa_pkg::MODE_RESIZE:
            begin
                if (target > TABLE_SLOTS)
                begin
                    target   = TABLE_SLOTS;
                    r.status = stffa_pkg::ST_FULL;
                end
                for (i = target; i < TABLE_SLOTS; i++)
                begin
                    if (slot_taken[i])
                    begin
                        slot_taken[i] = 1'b0;
                        taken_count--;
                    end
                end
                table_size = target;
            end
            default:
            begin
            end
        endcase
        r.slot  = slot[7:0];
        r.valid = (slot < table_size) && slot_taken[slot] &&
                  !(op == stffa_pkg::MODE_INSERT && r.status == stffa_pkg::ST_FULL);
        r.used  = 9'(taken_count);
        r.size  = 9'(table_size);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        table_reply_t due;
        table_reply_t seen;
        int           i;
        if (!rst_n)
        begin
            for (i = 0; i < TABLE_SLOTS; i++)
                slot_taken[i] = 1'b0;
            table_size   = 0;
            taken_count  = 0;
            grow_by      = 1;
            replies_due.delete();
            mismatches   = 0;
            results_seen = 0;
            outstanding  = 0;
            size_hint   <= '0;
        end
        else
        begin
            if (done)
            begin
                seen = {slot_out, value_out, slot_valid, stffa_pkg::status_t'(status),
                        used_count, active_size};
                results_seen++;
                if (replies_due.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("[%0t] result with no request outstanding: slot %0d status %0d",
                                 $realtime, slot_out, status);
                    mismatches++;
                end
                else
                begin
                    due = replies_due.pop_front();
                    if (seen !== due)
                    begin
                        if (mismatches < 10)
                        begin
                            $display("[%0t] mismatch, expected/actual:", $realtime);
                            $display("  slot %0d/%0d value %h/%h valid %0d/%0d",
                                     due.slot, seen.slot, due.value, seen.value,
                                     due.valid, seen.valid);
                            $display("  status %0d/%0d used %0d/%0d size %0d/%0d",
                                     due.status, seen.status, due.used, seen.used,
                                     due.size, seen.size);
                        end
                        mismatches++;
                    end
                end
            end
            if (cfg_we)
                grow_by = cfg_wdata;
            if (start && !busy)
                replies_due.push_back(apply_request(mode, slot_index, value_in, new_size));
            outstanding  = replies_due.size();
            size_hint   <= 9'(table_size);
        end
    end

endmodule

>>> sim/slot_table_first_free_alloc_tb.sv
`timescale 1ns / 1ps
// Testbench top for slot_table_first_free_alloc: drives requests and grow-step writes.
// Depends on stffa_pkg, the block itself and stffa_table_monitor, which does the checking.
module slot_table_first_free_alloc_tb;

    // Modes 6 and 7 are not operations; the block must treat them as no-ops.
    localparam logic [2:0] MODE_SPARE_LO = 3'd6;
    localparam logic [2:0] MODE_SPARE_HI = 3'd7;

    localparam int ITEMS = 2000;

    // Generous upper bound on the whole run; a correct run finishes in a tiny
    // fraction of this even with every request a full-length resize.
    localparam longint RUN_LIMIT_NS = 5_000_000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [2:0]  mode = '0;
    logic [7:0]  slot_index = '0;
    logic [31:0] value_in = '0;
    logic [8:0]  new_size = '0;
    logic        cfg_we = 1'b0;
    logic [8:0]  cfg_wdata = '0;
    logic        done;
    logic [7:0]  slot_out;
    logic [31:0] value_out;
    logic        slot_valid;
    logic [1:0]  status;
    logic [8:0]  used_count;
    logic [8:0]  active_size;

    int          mismatches;
    int          results_seen;
    int          outstanding;
    logic [8:0]  size_hint;

    int          sent;
    int          ops_sent [8];
    int          grow_writes;
    int          phase;

    // Grow steps used in order at the first reconfigurations: a large step that
    // overshoots capacity, zero (acts as one), the full capacity, all ones, an
    // odd step, and one again. Later settings are random.
    logic [8:0]  grow_plan [6] = '{9'd100, 9'd0, 9'd256, 9'd511, 9'd17, 9'd1};

    slot_table_first_free_alloc u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .mode        (mode),
        .slot_index  (slot_index),
        .value_in    (value_in),
        .new_size    (new_size),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .done        (done),
        .slot_out    (slot_out),
        .value_out   (value_out),
        .slot_valid  (slot_valid),
        .status      (status),
        .used_count  (used_count),
        .active_size (active_size)
    );

    stffa_table_monitor u_monitor (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .mode         (mode),
        .slot_index   (slot_index),
        .value_in     (value_in),
        .new_size     (new_size),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .done         (done),
        .slot_out     (slot_out),
        .value_out    (value_out),
        .slot_valid   (slot_valid),
        .status       (status),
        .used_count   (used_count),
        .active_size  (active_size),
        .mismatches   (mismatches),
        .results_seen (results_seen),
        .outstanding  (outstanding),
        .size_hint    (size_hint)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    initial
    begin
        #(RUN_LIMIT_NS);
        $display("slot_table_first_free_alloc_tb: done, errors");
        $finish;
    end

    // Drops start and lets the given number of cycles pass.
    task automatic idle_for(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // Presents one request and returns at the edge that accepts it. Start is
    // left high so that back-to-back requests keep it asserted; a random gap
    // follows now and then, except in a stretch in the middle of the run where
    // the block is kept saturated.
    task automatic send_request(input logic [2:0] op, input logic [7:0] idx,
                                input logic [31:0] val, input logic [8:0] want);
        start      <= 1'b1;
        mode       <= op;
        slot_index <= idx;
        value_in   <= val;
        new_size   <= want;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        ops_sent[op]++;
        sent++;
        if ((sent < 600 || sent >= 1100) && $urandom_range(0, 99) < 9)
            idle_for($urandom_range(1, 24));
    endtask

    // Holds off until every outstanding request has produced its result, then
    // lets the block settle before returning.
    task automatic wait_empty();
        start <= 1'b0;
        @(negedge clk);
        while (outstanding != 0)
            @(negedge clk);
        repeat (24) @(posedge clk);
    endtask

    // The grow step is only changed with the block idle.
    task automatic write_grow(input logic [8:0] step);
        wait_empty();
        cfg_we    <= 1'b1;
        cfg_wdata <= step;
        @(posedge clk);
        cfg_we    <= 1'b0;
        grow_writes++;
    endtask

    // Mostly an index inside the active table, sometimes the first slot past
    // its end, sometimes anywhere.
    function automatic logic [7:0] aim_index();
        int lim;
        int roll;
        lim  = size_hint;
        roll = $urandom_range(0, 99);
        if (lim > 0 && roll < 85)
            return 8'($urandom_range(0, lim - 1));
        else if (roll < 92 && lim < 256)
            return lim[7:0];
        else
            return 8'($urandom_range(0, 255));
    endfunction

    // Resize targets: mostly moderate, with empty, full and oversize requests.
    function automatic logic [8:0] pick_size();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 5)
            return 9'($urandom_range(257, 511));
        else if (roll < 10)
            return 9'd256;
        else if (roll < 18)
            return 9'd0;
        else
            return 9'($urandom_range(1, 160));
    endfunction

    // A realistic mix of table traffic aimed at live slots.
    task automatic churn(input int count);
        int roll;
        repeat (count)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 30)
                send_request(stffa_pkg::MODE_INSERT, 8'($urandom), $urandom, 9'($urandom));
            else if (roll < 45)
                send_request(stffa_pkg::MODE_WRITE, aim_index(), $urandom, 9'($urandom));
            else if (roll < 63)
                send_request(stffa_pkg::MODE_REMOVE, aim_index(), $urandom, 9'($urandom));
            else if (roll < 81)
                send_request(stffa_pkg::MODE_READ, aim_index(), $urandom, 9'($urandom));
            else if (roll < 89)
                send_request(stffa_pkg::MODE_QUERY, aim_index(), $urandom, 9'($urandom));
            else if (roll < 95)
                send_request(stffa_pkg::MODE_RESIZE, aim_index(), $urandom, pick_size());
            else
                send_request(($urandom_range(0, 1) != 0) ? MODE_SPARE_HI : MODE_SPARE_LO,
                             8'($urandom), $urandom, 9'($urandom));
        end
    endtask

    // Fully random fields, unknown modes and out-of-range sizes included.
    task automatic noise(input int count);
        repeat (count)
            send_request(3'($urandom_range(0, 7)), 8'($urandom), $urandom,
                         9'($urandom_range(0, 511)));
    endtask

    // Resizes interleaved with accesses near the moving boundary.
    task automatic resize_mix(input int count);
        repeat (count)
        begin
            send_request(stffa_pkg::MODE_RESIZE, aim_index(), $urandom, pick_size());
            send_request(stffa_pkg::MODE_QUERY, aim_index(), $urandom, 9'($urandom));
            send_request(stffa_pkg::MODE_WRITE, aim_index(), $urandom, 9'($urandom));
            send_request(stffa_pkg::MODE_READ, aim_index(), $urandom, 9'($urandom));
        end
    endtask

    // Shrinks the table, then inserts until it has grown to capacity and
    // overflowed a few times; then punches holes and refills them so the
    // first-free search lands in the middle of a full table.
    task automatic fill_table();
        send_request(stffa_pkg::MODE_RESIZE, 8'($urandom), $urandom,
                     9'($urandom_range(0, 12)));
        repeat (262)
            send_request(stffa_pkg::MODE_INSERT, 8'($urandom), $urandom, 9'($urandom));
        repeat (6)
            send_request(stffa_pkg::MODE_REMOVE, aim_index(), $urandom, 9'($urandom));
        repeat (7)
            send_request(stffa_pkg::MODE_INSERT, 8'($urandom), $urandom, 9'($urandom));
        repeat (5)
            send_request(stffa_pkg::MODE_READ, aim_index(), $urandom, 9'($urandom));
    endtask

    initial
    begin
        sent        = 0;
        grow_writes = 0;
        foreach (ops_sent[i])
            ops_sent[i] = 0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed opening with the reset grow step of one, starting from an
        // empty table: range errors on an empty table, growth by insert, data
        // extremes, removal and reads of unused slots, first-free reuse, an
        // oversize resize, the top slot, unknown modes and shrinking to zero.
        send_request(stffa_pkg::MODE_READ,   8'd0,   32'h0000_0000, 9'd0);
        send_request(stffa_pkg::MODE_INSERT, 8'd0,   32'h0000_0000, 9'd0);
        send_request(stffa_pkg::MODE_INSERT, 8'd0,   32'hFFFF_FFFF, 9'd0);
        send_request(stffa_pkg::MODE_WRITE,  8'd1,   32'hA5A5_A5A5, 9'd0);
        send_request(stffa_pkg::MODE_READ,   8'd1,   32'h0000_0000, 9'd0);
        send_request(stffa_pkg::MODE_QUERY,  8'd2,   32'h0000_0000, 9'd0);
        send_request(stffa_pkg::MODE_REMOVE, 8'd0,   32'h0000_0000, 9'd0);
        send_request(stffa_pkg::MODE_REMOVE, 8'd0,   32'h0000_0000, 9'd0);
        send_request(stffa_pkg::MODE_READ,   8'd0,   32'h0000_0000, 9'd0);
        send_request(stffa_pkg::MODE_INSERT, 8'd0,   32'h1234_5678, 9'd0);
        send_request(stffa_pkg::MODE_WRITE,  8'd255, 32'h5A5A_5A5A, 9'd0);
        send_request(stffa_pkg::MODE_RESIZE, 8'd0,   32'h0000_0000, 9'd300);
        send_request(stffa_pkg::MODE_QUERY,  8'd255, 32'h0000_0000, 9'd0);
        send_request(stffa_pkg::MODE_WRITE,  8'd255, 32'h8000_0001, 9'd0);
        send_request(stffa_pkg::MODE_READ,   8'd255, 32'h0000_0000, 9'd0);
        send_request(stffa_pkg::MODE_INSERT, 8'd0,   32'h7FFF_FFFE, 9'd0);
        send_request(stffa_pkg::MODE_REMOVE, 8'd3,   32'h0000_0000, 9'd0);
        send_request(MODE_SPARE_LO,          8'd200, 32'hDEAD_BEEF, 9'd511);
        send_request(MODE_SPARE_HI,          8'd1,   32'h0000_0000, 9'd0);
        send_request(stffa_pkg::MODE_RESIZE, 8'd255, 32'h0000_0000, 9'd2);
        send_request(stffa_pkg::MODE_READ,   8'd255, 32'h0000_0000, 9'd0);
        send_request(stffa_pkg::MODE_RESIZE, 8'd0,   32'h0000_0000, 9'd0);
        send_request(stffa_pkg::MODE_INSERT, 8'd0,   32'hC3C3_C3C3, 9'd0);
        send_request(stffa_pkg::MODE_RESIZE, 8'd0,   32'h0000_0000, 9'd256);
        send_request(stffa_pkg::MODE_RESIZE, 8'd0,   32'h0000_0000, 9'd511);

        // Random phases. Every third phase retunes the grow step with the block
        // drained; three of the early phases fill the table to overflow under
        // different grow steps.
        phase = 0;
        while (sent < ITEMS)
        begin
            if (phase % 3 == 0)
                write_grow((phase / 3 < 6) ? grow_plan[phase / 3]
                                           : 9'($urandom_range(1, 256)));
            if (phase == 1 || phase == 4 || phase == 7)
                fill_table();
            else
            begin
                case ($urandom_range(0, 5))
                    3:       noise(20);
                    4:       resize_mix($urandom_range(6, 12));
                    default: churn($urandom_range(40, 90));
                endcase
            end
            phase++;
        end

        wait_empty();

        $display("Sent %0d requests: ins %0d wr %0d rm %0d rd %0d qry %0d rsz %0d other %0d",
                 sent, ops_sent[stffa_pkg::MODE_INSERT], ops_sent[stffa_pkg::MODE_WRITE],
                 ops_sent[stffa_pkg::MODE_REMOVE], ops_sent[stffa_pkg::MODE_READ],
                 ops_sent[stffa_pkg::MODE_QUERY], ops_sent[stffa_pkg::MODE_RESIZE],
                 ops_sent[MODE_SPARE_LO] + ops_sent[MODE_SPARE_HI]);
        $display("Grow step rewritten %0d times; %0d results compared, %0d mismatched.",
                 grow_writes, results_seen, mismatches);
        if (mismatches == 0 && outstanding == 0)
            $display("slot_table_first_free_alloc_tb: done, clean");
        else
            $display("slot_table_first_free_alloc_tb: done, errors");
        $finish;
    end

endmodule
